FILE: design/ttl_pkg.sv
package ttl_pkg;

	localparam int unsigned N_LANES = 3;

	localparam logic [2:0]  MAX_LAPS     = 3'd5;
	localparam logic [6:0]  CENTI_LAST   = 7'd99;
	localparam logic [5:0]  SEC_LAST     = 6'd59;
	localparam logic [11:0] THRESH_RST   = 12'd500;
	localparam logic [15:0] STUCK_RST    = 16'd700;
	localparam logic [7:0]  QUAL_INIT    = 8'hFF;
	localparam logic [7:0]  QUAL_FIRE    = 8'd3;
	localparam logic [15:0] COUNT_SAT    = 16'hFFFF;

	// Configuration register indexes
	localparam logic REG_THRESHOLD   = 1'b0;
	localparam logic REG_STUCK_LIMIT = 1'b1;

	// Error source codes
	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_START  = 3'd1;
	localparam logic [2:0] ERR_RESET  = 3'd2;
	localparam logic [2:0] ERR_LANE_A = 3'd3;

	// Beat kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TIME   = 1'b1;

	typedef struct packed {
		logic stuck;
		logic fire;
	} qual_stat_t;

	typedef struct packed {
		logic [7:0] minutes;
		logic [5:0] seconds;
		logic [6:0] centis;
	} lap_time_t;

endpackage

FILE: design/three_lane_lap_timer.sv
// An accepted beat's result is registered in the result register, or in the
// skid register if that is held: a two-entry output stage that absorbs stall.
// One input beat per cycle unless in_stall; all work is one combinational
// pass from the input ports into the timer state and the result register.
// Reset: asynchronous, active low; clock, laps, captures, errors and qualifier
// run counts clear, histories load all ones, registers take their defaults.
module three_lane_lap_timer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic        start_pressed,
	input  logic        reset_pressed,
	input  logic [11:0] sensor_lane_a,
	input  logic [11:0] sensor_lane_b,
	input  logic [11:0] sensor_lane_c,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        running,
	output logic [2:0]  error_source,
	output logic [2:0]  laps_lane_a,
	output logic [2:0]  laps_lane_b,
	output logic [2:0]  laps_lane_c,
	output logic [20:0] clock_now,
	output logic [20:0] lane_a_time,
	output logic [20:0] lane_b_time,
	output logic [20:0] lane_c_time,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	typedef struct packed {
		logic       running;
		logic [2:0] err;
		logic [2:0] laps_a;
		logic [2:0] laps_b;
		logic [2:0] laps_c;
		logic [20:0] now;
		logic [20:0] time_a;
		logic [20:0] time_b;
		logic [20:0] time_c;
	} result_t;

	logic [11:0] thresh_q;
	logic [15:0] limit_q;

	ttl_pkg::lap_time_t clk_q, clk_nxt;
	logic               en_q, en_nxt;
	logic [2:0]         err_q, err_nxt;
	logic [2:0]         lap_q   [ttl_pkg::N_LANES];
	logic [2:0]         lap_nxt [ttl_pkg::N_LANES];
	logic [20:0]        cap_q   [ttl_pkg::N_LANES];
	logic [20:0]        cap_nxt [ttl_pkg::N_LANES];

	logic [11:0] sensor [ttl_pkg::N_LANES];
	ttl_pkg::qual_stat_t start_st, reset_st;
	ttl_pkg::qual_stat_t lane_st [ttl_pkg::N_LANES];

	logic    accept, sample_beat, time_beat, lanes_run;
	logic    en_a, en_b;
	logic [2:0] err_a, err_b;
	logic    clear;
	result_t res, res_q, skid_q;
	logic    res_v_q, skid_v_q, take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= ttl_pkg::THRESH_RST;
			limit_q  <= ttl_pkg::STUCK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ttl_pkg::REG_THRESHOLD:   thresh_q <= cfg_data[11:0];
				ttl_pkg::REG_STUCK_LIMIT: limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall    = skid_v_q;
	assign accept      = in_valid && !in_stall;
	assign sample_beat = accept && (kind == ttl_pkg::KIND_SAMPLE);
	assign time_beat   = accept && (kind == ttl_pkg::KIND_TIME);

	assign sensor[0] = sensor_lane_a;
	assign sensor[1] = sensor_lane_b;
	assign sensor[2] = sensor_lane_c;

	ttl_qual u_qual_start (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (sample_beat),
		.active (start_pressed),
		.limit  (limit_q),
		.stat   (start_st)
	);

	ttl_qual u_qual_reset (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (sample_beat),
		.active (reset_pressed),
		.limit  (limit_q),
		.stat   (reset_st)
	);

	for (genvar g = 0; g < ttl_pkg::N_LANES; g++) begin : g_lane
		ttl_qual u_qual_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (sample_beat && lanes_run),
			.active (sensor[g] < thresh_q),
			.limit  (limit_q),
			.stat   (lane_st[g])
		);
	end

	always_comb begin
		// start button: stuck disables, event toggles
		en_a  = start_st.stuck ? 1'b0 : en_q;
		err_a = start_st.stuck ? ttl_pkg::ERR_START : err_q;
		if (start_st.fire) begin
			en_a = !en_a;
		end

		// reset button: event clears the whole timer
		en_b  = reset_st.stuck ? 1'b0 : en_a;
		err_b = reset_st.stuck ? ttl_pkg::ERR_RESET : err_a;
		clear = reset_st.fire;
		if (clear) begin
			en_b  = 1'b0;
			err_b = ttl_pkg::ERR_NONE;
		end

		lanes_run = en_b;
		en_nxt    = en_b;
		err_nxt   = err_b;
		clk_nxt   = clk_q;
		for (int i = 0; i < ttl_pkg::N_LANES; i++) begin
			lap_nxt[i] = lap_q[i];
			cap_nxt[i] = cap_q[i];
		end

		if (sample_beat) begin
			if (clear) begin
				clk_nxt = '0;
				for (int i = 0; i < ttl_pkg::N_LANES; i++) begin
					lap_nxt[i] = '0;
					cap_nxt[i] = '0;
				end
			end
			if (lanes_run) begin
				for (int i = 0; i < ttl_pkg::N_LANES; i++) begin
					if (lane_st[i].stuck) begin
						en_nxt  = 1'b0;
						err_nxt = ttl_pkg::ERR_LANE_A + 3'(i);
					end
					if (lane_st[i].fire) begin
						lap_nxt[i] = (lap_q[i] >= ttl_pkg::MAX_LAPS) ?
							ttl_pkg::MAX_LAPS : lap_q[i] + 3'd1;
						cap_nxt[i] = clk_q;
					end
				end
			end
		end else begin
			en_nxt  = en_q;
			err_nxt = err_q;
			if (time_beat && en_q) begin
				// advance centiseconds, carry into seconds and minutes
				if (clk_q.centis >= ttl_pkg::CENTI_LAST) begin
					clk_nxt.centis = '0;
					if (clk_q.seconds >= ttl_pkg::SEC_LAST) begin
						clk_nxt.seconds = '0;
						clk_nxt.minutes = clk_q.minutes + 8'd1;
					end else begin
						clk_nxt.seconds = clk_q.seconds + 6'd1;
					end
				end else begin
					clk_nxt.centis = clk_q.centis + 7'd1;
				end
			end
		end

		res.running = en_nxt;
		res.err     = err_nxt;
		res.laps_a  = lap_nxt[0];
		res.laps_b  = lap_nxt[1];
		res.laps_c  = lap_nxt[2];
		res.now     = clk_nxt;
		res.time_a  = cap_nxt[0];
		res.time_b  = cap_nxt[1];
		res.time_c  = cap_nxt[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_q <= '0;
			en_q  <= 1'b0;
			err_q <= ttl_pkg::ERR_NONE;
			for (int i = 0; i < ttl_pkg::N_LANES; i++) begin
				lap_q[i] <= '0;
				cap_q[i] <= '0;
			end
		end else if (accept) begin
			clk_q <= clk_nxt;
			en_q  <= en_nxt;
			err_q <= err_nxt;
			for (int i = 0; i < ttl_pkg::N_LANES; i++) begin
				lap_q[i] <= lap_nxt[i];
				cap_q[i] <= cap_nxt[i];
			end
		end
	end

	// Output stage: result register backed by one skid entry
	assign take = res_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (accept) begin
			if (!res_v_q || take) begin
				res_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			res_v_q  <= skid_v_q;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!res_v_q || take) begin
				res_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (take && skid_v_q) begin
			res_q <= skid_q;
		end
	end

	assign out_valid    = res_v_q;
	assign running      = res_q.running;
	assign error_source = res_q.err;
	assign laps_lane_a  = res_q.laps_a;
	assign laps_lane_b  = res_q.laps_b;
	assign laps_lane_c  = res_q.laps_c;
	assign clock_now    = res_q.now;
	assign lane_a_time  = res_q.time_a;
	assign lane_b_time  = res_q.time_b;
	assign lane_c_time  = res_q.time_c;

endmodule

FILE: design/ttl_qual.sv
module ttl_qual (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                active,
	input  logic [15:0]         limit,
	output ttl_pkg::qual_stat_t stat
);

	logic [7:0]  shift_q;
	logic [15:0] count_q;
	logic [7:0]  shift_nxt;
	logic [15:0] count_nxt;
	logic        stuck;

	always_comb begin
		stuck = active && (count_q > limit);
		if (active) begin
			count_nxt = (count_q == ttl_pkg::COUNT_SAT) ? count_q : count_q + 16'd1;
			shift_nxt = stuck ? shift_q : {shift_q[6:0], 1'b1};
		end else begin
			count_nxt = '0;
			shift_nxt = {shift_q[6:0], 1'b0};
		end
		stat.stuck = stuck;
		stat.fire  = (shift_nxt == ttl_pkg::QUAL_FIRE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= ttl_pkg::QUAL_INIT;
			count_q <= '0;
		end else if (step) begin
			shift_q <= shift_nxt;
			count_q <= count_nxt;
		end
	end

endmodule

FILE: tb/lap_timer_checker.sv
`timescale 1ns / 100ps

module lap_timer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        kind,
	input  logic        start_pressed,
	input  logic        reset_pressed,
	input  logic [11:0] sensor_lane_a,
	input  logic [11:0] sensor_lane_b,
	input  logic [11:0] sensor_lane_c,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        running,
	input  logic [2:0]  error_source,
	input  logic [2:0]  laps_lane_a,
	input  logic [2:0]  laps_lane_b,
	input  logic [2:0]  laps_lane_c,
	input  logic [20:0] clock_now,
	input  logic [20:0] lane_a_time,
	input  logic [20:0] lane_b_time,
	input  logic [20:0] lane_c_time,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          readouts_owed
);

	localparam int SLOTS   = int'(ttl_pkg::MAX_LAPS) + 1;
	localparam int N_QUAL  = 5;
	localparam int Q_START = 0;
	localparam int Q_RESET = 1;
	localparam int Q_LANE0 = 2;

	typedef struct packed {
		logic        running;
		logic [2:0]  error_source;
		logic [2:0]  laps_a;
		logic [2:0]  laps_b;
		logic [2:0]  laps_c;
		logic [20:0] clock_now;
		logic [20:0] time_a;
		logic [20:0] time_b;
		logic [20:0] time_c;
	} readout_t;

	logic [11:0]        threshold;
	logic [15:0]        stuck_limit;
	ttl_pkg::lap_time_t watch;
	logic               enabled;
	logic [2:0]         last_error;
	logic [15:0]        active_run [N_QUAL];
	logic [7:0]         shift_hist [N_QUAL];
	logic [2:0]         laps [ttl_pkg::N_LANES];
	logic [20:0]        captures [ttl_pkg::N_LANES][SLOTS];
	readout_t           pending_readouts [$];
	int                 mismatches = 0;
	int                 owed = 0;

	assign fail_count    = mismatches;
	assign readouts_owed = owed;

	function automatic void clear_race();
		watch      = '0;
		enabled    = 1'b0;
		last_error = ttl_pkg::ERR_NONE;
		for (int i = 0; i < ttl_pkg::N_LANES; i++) begin
			laps[i] = '0;
			for (int s = 0; s < SLOTS; s++)
				captures[i][s] = '0;
		end
	endfunction

	function automatic void power_on_timer();
		threshold   = ttl_pkg::THRESH_RST;
		stuck_limit = ttl_pkg::STUCK_RST;
		clear_race();
		for (int q = 0; q < N_QUAL; q++) begin
			active_run[q] = '0;
			shift_hist[q] = ttl_pkg::QUAL_INIT;
		end
	endfunction

	// Compare the old run length with the limit, then count; fire on exactly 0b11.
	function automatic logic step_qualifier(int q, logic active, logic [2:0] code);
		if (active) begin
			if (active_run[q] > stuck_limit) begin
				enabled    = 1'b0;
				last_error = code;
			end else begin
				shift_hist[q] = {shift_hist[q][6:0], 1'b1};
			end
			if (active_run[q] != ttl_pkg::COUNT_SAT)
				active_run[q] = active_run[q] + 16'd1;
		end else begin
			active_run[q] = '0;
			shift_hist[q] = {shift_hist[q][6:0], 1'b0};
		end
		return shift_hist[q] == ttl_pkg::QUAL_FIRE;
	endfunction

	function automatic readout_t advance_timer(logic k, logic st, logic rs,
			logic [11:0] a, logic [11:0] b, logic [11:0] c);
		logic [11:0] level [ttl_pkg::N_LANES];
		logic        lanes_live;
		readout_t    r;
		level = '{a, b, c};
		if (k == ttl_pkg::KIND_TIME) begin
			if (enabled) begin
				if (watch.centis == ttl_pkg::CENTI_LAST) begin
					watch.centis = '0;
					if (watch.seconds == ttl_pkg::SEC_LAST) begin
						watch.seconds = '0;
						watch.minutes = watch.minutes + 8'd1;
					end else begin
						watch.seconds = watch.seconds + 6'd1;
					end
				end else begin
					watch.centis = watch.centis + 7'd1;
				end
			end
		end else begin
			if (step_qualifier(Q_START, st, ttl_pkg::ERR_START))
				enabled = !enabled;
			if (step_qualifier(Q_RESET, rs, ttl_pkg::ERR_RESET))
				clear_race();
			// the lane stage runs whole even if a lane sticks partway
			lanes_live = enabled;
			if (lanes_live) begin
				for (int i = 0; i < ttl_pkg::N_LANES; i++) begin
					if (step_qualifier(Q_LANE0 + i, level[i] < threshold,
							3'(ttl_pkg::ERR_LANE_A + i))) begin
						if (laps[i] != ttl_pkg::MAX_LAPS)
							laps[i] = laps[i] + 3'd1;
						captures[i][laps[i]] = watch;
					end
				end
			end
		end
		r.running      = enabled;
		r.error_source = last_error;
		r.laps_a       = laps[0];
		r.laps_b       = laps[1];
		r.laps_c       = laps[2];
		r.clock_now    = watch;
		r.time_a       = captures[0][laps[0]];
		r.time_b       = captures[1][laps[1]];
		r.time_c       = captures[2][laps[2]];
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			if (mismatches < 10)
				$display("%t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : beat_watch
		readout_t due;
		if (!arst_n) begin
			power_on_timer();
			pending_readouts.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_readouts.size() == 0) begin
					if (mismatches < 10)
						$display("%t result beat with none due, clock_now %0d",
							$time, clock_now);
					mismatches++;
				end else begin
					due = pending_readouts.pop_front();
					check_field("running", 32'(due.running), 32'(running));
					check_field("error_source", 32'(due.error_source),
						32'(error_source));
					check_field("laps_lane_a", 32'(due.laps_a), 32'(laps_lane_a));
					check_field("laps_lane_b", 32'(due.laps_b), 32'(laps_lane_b));
					check_field("laps_lane_c", 32'(due.laps_c), 32'(laps_lane_c));
					check_field("clock_now", 32'(due.clock_now), 32'(clock_now));
					check_field("lane_a_time", 32'(due.time_a), 32'(lane_a_time));
					check_field("lane_b_time", 32'(due.time_b), 32'(lane_b_time));
					check_field("lane_c_time", 32'(due.time_c), 32'(lane_c_time));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ttl_pkg::REG_THRESHOLD)
					threshold = cfg_data[11:0];
				else
					stuck_limit = cfg_data;
			end
			if (in_valid && !in_stall)
				pending_readouts.push_back(advance_timer(kind, start_pressed, reset_pressed,
					sensor_lane_a, sensor_lane_b, sensor_lane_c));
		end
		owed = pending_readouts.size();
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic        start_pressed;
	logic        reset_pressed;
	logic [11:0] sensor_lane_a;
	logic [11:0] sensor_lane_b;
	logic [11:0] sensor_lane_c;
	logic        out_valid;
	logic        out_stall;
	logic        running;
	logic [2:0]  error_source;
	logic [2:0]  laps_lane_a;
	logic [2:0]  laps_lane_b;
	logic [2:0]  laps_lane_c;
	logic [20:0] clock_now;
	logic [20:0] lane_a_time;
	logic [20:0] lane_b_time;
	logic [20:0] lane_c_time;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;
	int          fail_count;
	int          readouts_owed;

	bit          steady = 1'b0;
	logic [11:0] threshold_now = ttl_pkg::THRESH_RST;
	int          beats_sent = 0;

	three_lane_lap_timer uut (.*);

	lap_timer_checker monitor_u (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Result side: stall at random, except in steady mode, before taking each beat.
	initial begin
		int hold;
		forever begin
			hold = steady ? 0 : $urandom_range(0, 12);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic send_beat(logic k, logic st, logic rs,
			logic [11:0] a, logic [11:0] b, logic [11:0] c);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		kind          <= k;
		start_pressed <= st;
		reset_pressed <= rs;
		sensor_lane_a <= a;
		sensor_lane_b <= b;
		sensor_lane_c <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		beats_sent++;
	endtask

	function automatic logic [11:0] lane_value(logic active);
		int pick;
		pick = $urandom_range(0, 7);
		if (active && threshold_now != 0) begin
			if (pick == 0)
				return threshold_now - 12'd1;
			if (pick == 1)
				return 12'd0;
			return 12'($urandom_range(0, threshold_now - 1));
		end
		if (!active) begin
			if (pick == 0)
				return threshold_now;
			if (pick == 1)
				return 12'hFFF;
			return 12'($urandom_range(threshold_now, 4095));
		end
		return 12'($urandom);
	endfunction

	task automatic send_tick();
		send_beat(ttl_pkg::KIND_TIME, 1'($urandom), 1'($urandom),
			12'($urandom), 12'($urandom), 12'($urandom));
	endtask

	task automatic send_quiet(int n);
		repeat (n)
			send_beat(ttl_pkg::KIND_SAMPLE, 1'b0, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF);
	endtask

	// Sample beat with the given inputs active; a time beat slips in now and then.
	task automatic send_sample(logic st, logic rs, logic [2:0] hit);
		if ($urandom_range(0, 3) == 0)
			send_tick();
		send_beat(ttl_pkg::KIND_SAMPLE, st, rs, lane_value(hit[0]), lane_value(hit[1]),
			lane_value(hit[2]));
	endtask

	// Enough idle samples to clear the qualifier, then a short active burst.
	task automatic press(logic st, logic rs, logic [2:0] hit);
		repeat ($urandom_range(6, 8)) send_sample(1'b0, 1'b0, 3'b000);
		repeat ($urandom_range(2, 3)) send_sample(st, rs, hit);
	endtask

	task automatic hold_input();
		int which;
		int len;
		which = $urandom_range(0, 4);
		len   = $urandom_range(2, 24);
		repeat (len)
			send_sample(which == 0, which == 1, which < 2 ? 3'b000 : 3'(1 << (which - 2)));
	endtask

	task automatic send_noise();
		send_beat(($urandom_range(0, 3) == 0) ? ttl_pkg::KIND_TIME : ttl_pkg::KIND_SAMPLE,
			1'($urandom), 1'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (readouts_owed != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == ttl_pkg::REG_THRESHOLD)
			threshold_now = value[11:0];
	endtask

	task automatic run_scenarios(int budget);
		int stop_at;
		int pick;
		stop_at = beats_sent + budget;
		while (beats_sent < stop_at) begin
			if ($urandom_range(0, 19) == 0)
				steady = !steady;
			pick = $urandom_range(0, 99);
			if (pick < 22)
				repeat ($urandom_range(1, 40)) send_tick();
			else if (pick < 36)
				press(1'b1, 1'b0, 3'b000);
			else if (pick < 43)
				press(1'b0, 1'b1, 3'b000);
			else if (pick < 75)
				press(1'b0, 1'b0, 3'($urandom_range(1, 7)));
			else if (pick < 85)
				hold_input();
			else if (pick < 97)
				repeat ($urandom_range(1, 12)) send_noise();
			else
				wait_drained();
		end
		steady = 1'b0;
	endtask

	initial begin
		int drain;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		kind          <= ttl_pkg::KIND_SAMPLE;
		start_pressed <= 1'b0;
		reset_pressed <= 1'b0;
		sensor_lane_a <= 12'hFFF;
		sensor_lane_b <= 12'hFFF;
		sensor_lane_c <= 12'hFFF;
		cfg_valid     <= 1'b0;
		cfg_index     <= ttl_pkg::REG_THRESHOLD;
		cfg_data      <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle timer: time beat does nothing, lane stage is skipped.
		send_beat(ttl_pkg::KIND_TIME, 1'b1, 1'b1, 12'hFFF, 12'hFFF, 12'hFFF);
		send_beat(ttl_pkg::KIND_SAMPLE, 1'b1, 1'b1, 12'h000, 12'h000, 12'h000);
		send_quiet(6);
		repeat (2) send_beat(ttl_pkg::KIND_SAMPLE, 1'b1, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF);
		repeat (3) send_tick();
		send_quiet(6);
		send_beat(ttl_pkg::KIND_SAMPLE, 1'b0, 1'b0, 12'd0, 12'd499, 12'd500);
		send_beat(ttl_pkg::KIND_SAMPLE, 1'b0, 1'b0, 12'd499, 12'd0, 12'd500);
		send_quiet(6);
		repeat (2) send_beat(ttl_pkg::KIND_SAMPLE, 1'b0, 1'b1, 12'hFFF, 12'hFFF, 12'hFFF);
		run_scenarios(250);

		write_reg(ttl_pkg::REG_THRESHOLD, 16'd4095);
		write_reg(ttl_pkg::REG_STUCK_LIMIT, 16'd0);
		run_scenarios(200);

		write_reg(ttl_pkg::REG_THRESHOLD, 16'd0);
		write_reg(ttl_pkg::REG_STUCK_LIMIT, 16'd1);
		run_scenarios(150);

		write_reg(ttl_pkg::REG_THRESHOLD, 16'd2048);
		write_reg(ttl_pkg::REG_STUCK_LIMIT, 16'd3);
		run_scenarios(250);

		write_reg(ttl_pkg::REG_THRESHOLD, 16'($urandom_range(1, 4094)));
		write_reg(ttl_pkg::REG_STUCK_LIMIT, 16'($urandom_range(2, 20)));
		run_scenarios(200);

		write_reg(ttl_pkg::REG_THRESHOLD, 16'd1);
		write_reg(ttl_pkg::REG_STUCK_LIMIT, ttl_pkg::COUNT_SAT);
		run_scenarios(100);

		write_reg(ttl_pkg::REG_THRESHOLD, 16'(ttl_pkg::THRESH_RST));
		write_reg(ttl_pkg::REG_STUCK_LIMIT, 16'd5);
		run_scenarios(100);

		in_valid <= 1'b0;
		drain = 0;
		@(posedge clk);
		while (readouts_owed != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (4) @(posedge clk);
		if (fail_count == 0 && readouts_owed == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
design/ttl_pkg.sv
design/ttl_qual.sv
design/three_lane_lap_timer.sv
tb/lap_timer_checker.sv
tb/testbench.sv
